### rtl/f8pf_pkg.sv
// ----------------------------------------------------------------------------
// Fletcher-8 packet framer package
// Shared constants and types for the framer datapath and its output stage.
// ----------------------------------------------------------------------------
package f8pf_pkg;

  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned POS_W       = $clog2(MAX_RESULTS);

  typedef logic [7:0]       byte_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [POS_W-1:0] pos_t;

  localparam byte_t SYNC_FIRST_RESET  = 8'hAA;
  localparam byte_t SYNC_SECOND_RESET = 8'h55;

  typedef enum logic [0:0] {
    REG_SYNC_FIRST  = 1'b0,
    REG_SYNC_SECOND = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    cnt_t                        count;
    logic                        trailer;
  } burst_t;

endpackage

### rtl/f8pf_frame_core.sv
// ----------------------------------------------------------------------------
// Fletcher-8 framer core
// Holds the frame state and builds the burst of framed bytes for one item.
// ----------------------------------------------------------------------------
module f8pf_frame_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  f8pf_pkg::byte_t  data_byte,
  input  f8pf_pkg::byte_t  payload_length,
  input  f8pf_pkg::byte_t  sync_first,
  input  f8pf_pkg::byte_t  sync_second,
  output f8pf_pkg::burst_t burst
);
  import f8pf_pkg::*;

  byte_t bytes_remaining;
  byte_t sum_a;
  byte_t sum_b;
  byte_t bytes_remaining_next;
  byte_t sum_a_next;
  byte_t sum_b_next;
  cnt_t  n;

  always_comb begin
    burst       = '0;
    n           = '0;
    sum_a_next  = sum_a;
    sum_b_next  = sum_b;
    bytes_remaining_next = bytes_remaining;
    if (bytes_remaining == 8'd0) begin
      burst.bytes[0] = sync_first;
      burst.bytes[1] = sync_second;
      burst.bytes[2] = payload_length;
      if (payload_length != 8'd0) begin
        burst.bytes[3]       = data_byte;
        sum_a_next           = payload_length + data_byte;
        sum_b_next           = payload_length + sum_a_next;
        bytes_remaining_next = payload_length - 8'd1;
        n                    = cnt_t'(4);
      end else begin
        sum_a_next           = payload_length;
        sum_b_next           = payload_length;
        bytes_remaining_next = 8'd0;
        n                    = cnt_t'(3);
      end
    end else begin
      burst.bytes[0]       = data_byte;
      sum_a_next           = sum_a + data_byte;
      sum_b_next           = sum_b + sum_a_next;
      bytes_remaining_next = bytes_remaining - 8'd1;
      n                    = cnt_t'(1);
    end
    if (bytes_remaining_next == 8'd0) begin
      burst.bytes[pos_t'(n)]          = sum_a_next;
      burst.bytes[pos_t'(n + cnt_t'(1))] = sum_b_next;
      n             = n + cnt_t'(2);
      burst.trailer = 1'b1;
    end
    burst.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      sum_a           <= '0;
      sum_b           <= '0;
    end else if (accept) begin
      bytes_remaining <= bytes_remaining_next;
      sum_a           <= sum_a_next;
      sum_b           <= sum_b_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (burst.count != cnt_t'(0)) && (burst.count <= cnt_t'(MAX_RESULTS)))
    else $error("Burst length out of range.");

  a_trailer_at_end: assert property (@(posedge clk) disable iff (rst)
    burst.trailer == (bytes_remaining_next == 8'd0))
    else $error("Checksum trailer does not match the end of the frame.");

  a_frame_idle_reset: assert property (@(posedge clk) disable iff (rst)
    (accept && burst.trailer) |=> (bytes_remaining == 8'd0))
    else $error("Frame state not idle after the trailer.");

endmodule

### rtl/f8pf_burst_ser.sv
// ----------------------------------------------------------------------------
// Fletcher-8 framer burst serializer
// Holds one burst of framed bytes and sends it out one byte per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module f8pf_burst_ser (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  output logic             load_ready,
  input  f8pf_pkg::burst_t burst_in,
  output logic             out_valid,
  input  logic             out_stall,
  output f8pf_pkg::byte_t  out_byte,
  output logic             run_last,
  output logic             frame_end
);
  import f8pf_pkg::*;

  burst_t buf_burst;
  logic   buf_valid;
  pos_t   buf_pos;
  logic   out_free;
  logic   move;
  logic   last_move;
  logic   load;

  assign out_free   = !out_valid || !out_stall;
  assign move       = buf_valid && out_free;
  assign last_move  = move && (cnt_t'(buf_pos) == buf_burst.count - cnt_t'(1));
  assign load_ready = !buf_valid || last_move;
  assign load       = load_valid && load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      buf_pos   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= move;
      end
      if (load) begin
        buf_valid <= 1'b1;
        buf_pos   <= '0;
      end else if (last_move) begin
        buf_valid <= 1'b0;
      end else if (move) begin
        buf_pos <= buf_pos + pos_t'(1);
      end
    end
    if (move) begin
      out_byte  <= buf_burst.bytes[buf_pos];
      run_last  <= last_move;
      frame_end <= last_move && buf_burst.trailer;
    end
    if (load) begin
      buf_burst <= burst_in;
    end
  end

  a_pos_in_burst: assert property (@(posedge clk) disable iff (rst)
    buf_valid |-> (cnt_t'(buf_pos) < buf_burst.count))
    else $error("Serializer position beyond burst length.");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    load |=> (buf_valid && (buf_pos == pos_t'(0))))
    else $error("Loaded burst does not start at its first byte.");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> run_last)
    else $error("Frame end not on the last byte of a transfer.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (buf_valid && !last_move) |-> !load)
    else $error("Burst overwritten before it was sent.");

endmodule

### rtl/fletcher8_packet_framer.sv
// ----------------------------------------------------------------------------
// Fletcher-8 packet framer
// Turns payload bytes into frames of sync, sync, length, payload, A and B.
//
//   channel   direction  handshake            payload
//   input     in         in_valid/in_stall    data_byte, payload_length
//   output    out        out_valid/out_stall  out_byte, run_last, frame_end
//   config    in         cfg_write            cfg_index, cfg_data
//
// A mid-frame payload byte yields one output byte and one transfer per cycle while out_stall is low.
// A frame's first or last item yields three to six bytes, and the input is
// stalled until the serializer holding that burst sends its last byte.
// The output byte register sits after the burst buffer, so a new item is
// taken while a finished byte still waits on out_stall.
// Reset clears the frame state and restores the sync bytes to 0xAA and 0x55.
// ----------------------------------------------------------------------------
module fletcher8_packet_framer (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  f8pf_pkg::byte_t data_byte,
  input  f8pf_pkg::byte_t payload_length,
  output logic            out_valid,
  input  logic            out_stall,
  output f8pf_pkg::byte_t out_byte,
  output logic            run_last,
  output logic            frame_end,
  input  logic            cfg_write,
  input  logic [0:0]      cfg_index,
  input  f8pf_pkg::byte_t cfg_data
);
  import f8pf_pkg::*;

  byte_t  sync_first;
  byte_t  sync_second;
  burst_t burst;
  logic   load_ready;
  logic   accept;

  assign in_stall = !load_ready;
  assign accept   = in_valid && load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RESET;
      sync_second <= SYNC_SECOND_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_SYNC_FIRST:  sync_first  <= cfg_data;
        REG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  f8pf_frame_core u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (data_byte),
    .payload_length (payload_length),
    .sync_first     (sync_first),
    .sync_second    (sync_second),
    .burst          (burst)
  );

  f8pf_burst_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .load_valid (in_valid),
    .load_ready (load_ready),
    .burst_in   (burst),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .frame_end  (frame_end)
  );

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Fletcher-8 packet framer testbench
// Sends payload bytes into the framer and checks every byte of the framed
// stream against a behavioral predictor. The predictor follows the sync bytes,
// the length, the payload and the two running checksums. The run covers
// directed frames, sync register changes, a maximum-length frame, random
// frames with random input gaps and output stalls, and a final stretch of
// back-to-back frames with no idling.
// ----------------------------------------------------------------------------
module testbench;
  import f8pf_pkg::*;

  typedef struct {
    byte_t value;
    logic  run_last;
    logic  frame_end;
  } stream_byte_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  byte_t      data_byte;
  byte_t      payload_length;
  logic       out_valid;
  logic       out_stall;
  byte_t      out_byte;
  logic       run_last;
  logic       frame_end;
  logic       cfg_write;
  logic [0:0] cfg_index;
  byte_t      cfg_data;

  stream_byte_t pending_stream[$];
  byte_t        sync_first_r;
  byte_t        sync_second_r;
  byte_t        payload_left;
  byte_t        sum_a;
  byte_t        sum_b;
  int unsigned  fail_count = 0;
  int unsigned  sent_items = 0;
  bit           in_idle_en;
  bit           out_idle_en;

  fletcher8_packet_framer u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .payload_length (payload_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .run_last       (run_last),
    .frame_end      (frame_end),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void push_stream_byte(byte_t value, logic is_frame_end);
    stream_byte_t entry;
    entry.value     = value;
    entry.run_last  = 1'b0;
    entry.frame_end = is_frame_end;
    pending_stream.push_back(entry);
  endfunction

  function automatic void fold_checksum(byte_t value);
    sum_a = sum_a + value;
    sum_b = sum_b + sum_a;
  endfunction

  function automatic void predict_framed_bytes(byte_t data, byte_t len);
    if (payload_left == 8'd0) begin
      push_stream_byte(sync_first_r, 1'b0);
      push_stream_byte(sync_second_r, 1'b0);
      push_stream_byte(len, 1'b0);
      sum_a = 8'd0;
      sum_b = 8'd0;
      fold_checksum(len);
      if (len != 8'd0) begin
        push_stream_byte(data, 1'b0);
        fold_checksum(data);
        payload_left = len - 8'd1;
      end
    end else begin
      push_stream_byte(data, 1'b0);
      fold_checksum(data);
      payload_left = payload_left - 8'd1;
    end
    if (payload_left == 8'd0) begin
      push_stream_byte(sum_a, 1'b0);
      push_stream_byte(sum_b, 1'b1);
    end
    pending_stream[pending_stream.size() - 1].run_last = 1'b1;
  endfunction

  // Called at a falling edge; returns at a falling edge with in_valid still
  // high so that back-to-back transfers follow without a gap.
  task automatic send_item(input byte_t data, input byte_t len);
    if (in_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= data;
    payload_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_framed_bytes(data, len);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_frame(input byte_t len, input bit use_fill, input byte_t fill);
    int n;
    n = (len == 8'd0) ? 1 : int'(len);
    for (int i = 0; i < n; i++) begin
      send_item(use_fill ? fill : byte_t'($urandom),
                (i == 0) ? len : byte_t'($urandom_range(0, 255)));
    end
  endtask

  task automatic drain_stream();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_stream.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input byte_t value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SYNC_FIRST:  sync_first_r  = value;
      REG_SYNC_SECOND: sync_second_r = value;
      default: ;
    endcase
  endtask

  task automatic test_defaults();
    send_frame(8'd0, 1'b0, 8'h00);
    send_frame(8'd1, 1'b1, 8'hFF);
    send_frame(8'd1, 1'b1, 8'h00);
    send_frame(8'd2, 1'b1, 8'hFF);
    send_frame(8'd3, 1'b0, 8'h00);
    drain_stream();
  endtask

  // The fourth write lands in the middle of a frame and must only show up
  // in the header of the frame that follows.
  task automatic test_sync_registers();
    write_reg(REG_SYNC_FIRST, 8'h00);
    write_reg(REG_SYNC_SECOND, 8'hFF);
    send_frame(8'd0, 1'b1, 8'hFF);
    send_frame(8'd2, 1'b1, 8'h00);
    drain_stream();
    write_reg(REG_SYNC_FIRST, 8'hFF);
    send_item(8'h5A, 8'd3);
    drain_stream();
    write_reg(REG_SYNC_SECOND, 8'h00);
    send_item(8'hA5, 8'd0);
    send_item(8'h3C, 8'd255);
    send_frame(8'd1, 1'b1, 8'hAA);
    drain_stream();
  endtask

  task automatic test_longest_frame();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    write_reg(REG_SYNC_FIRST, 8'hAA);
    write_reg(REG_SYNC_SECOND, 8'h55);
    send_frame(8'd255, 1'b1, 8'hFF);
    drain_stream();
  endtask

  task automatic test_random_frames();
    int    stop_at;
    int    pick;
    byte_t len;
    stop_at = sent_items + 20;
    while (sent_items < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        in_idle_en  = ($urandom_range(0, 2) != 0);
        out_idle_en = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 9) == 0) begin
        drain_stream();
        pick = $urandom_range(0, 3);
        if (pick != 1)
          write_reg(REG_SYNC_FIRST, ($urandom_range(0, 3) == 0) ? 8'hFF : byte_t'($urandom));
        if (pick != 0)
          write_reg(REG_SYNC_SECOND, ($urandom_range(0, 3) == 0) ? 8'h00 : byte_t'($urandom));
      end
      pick = $urandom_range(0, 99);
      if (pick < 10)
        len = 8'd0;
      else if (pick < 60)
        len = byte_t'($urandom_range(1, 4));
      else if (pick < 90)
        len = byte_t'($urandom_range(5, 16));
      else
        len = byte_t'($urandom_range(17, 60));
      send_frame(len, 1'b0, 8'h00);
    end
    drain_stream();
  endtask

  task automatic test_streaming_no_idle();
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    for (int i = 0; i < 6; i++) begin
      send_frame(byte_t'($urandom_range(0, 6)), 1'b0, 8'h00);
    end
    drain_stream();
  endtask

  always @(posedge clk) begin : check_stream
    stream_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_stream.size() == 0) begin
        $error("out_byte: expected no transfer, actual %02h", out_byte);
        fail_count++;
      end else begin
        want = pending_stream.pop_front();
        if (out_byte !== want.value) begin
          $error("out_byte: expected %02h, actual %02h", want.value, out_byte);
          fail_count++;
        end
        if (run_last !== want.run_last) begin
          $error("run_last: expected %0b, actual %0b", want.run_last, run_last);
          fail_count++;
        end
        if (frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, actual %0b", want.frame_end, frame_end);
          fail_count++;
        end
      end
    end
  end

  initial begin : out_stall_driver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (out_idle_en && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : run_tests
    rst            = 1'b1;
    in_valid       = 1'b0;
    data_byte      = 8'h00;
    payload_length = 8'h00;
    cfg_write      = 1'b0;
    cfg_index      = REG_SYNC_FIRST;
    cfg_data       = 8'h00;
    in_idle_en     = 1'b0;
    out_idle_en    = 1'b0;
    sync_first_r   = SYNC_FIRST_RESET;
    sync_second_r  = SYNC_SECOND_RESET;
    payload_left   = 8'd0;
    sum_a          = 8'd0;
    sum_b          = 8'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_defaults();
    test_sync_registers();
    test_longest_frame();
    test_random_frames();
    test_streaming_no_idle();

    repeat (16) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
